### hw/rtl/hbm_pkg.sv
// hbm_pkg: sizes, operation codes and request types of the bucketed hash map engine
// no dependencies
package hbm_pkg;
	localparam int BUCKETS  = 1024;
	localparam int SLOTS    = 32;
	localparam int LANES    = 4;
	localparam int ROWS     = SLOTS / LANES;
	localparam int BKT_W    = $clog2(BUCKETS);
	localparam int LANE_W   = $clog2(LANES);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int SLOT_W   = ROW_W + LANE_W;
	localparam int FILL_W   = $clog2(SLOTS + 1);
	localparam int ADDR_W   = BKT_W + ROW_W;
	localparam int DATA_W   = 32;
	localparam int MODE_W   = 2;

	localparam logic [MODE_W-1:0] MODE_GET   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_GET,
		OP_SET,
		OP_CLR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [BKT_W-1:0]  bucket;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FILL,
		ST_SCAN,
		ST_CLR,
		ST_RESP
	} state_t;
endpackage

### hw/rtl/hbm_req_if.sv
// hbm_req_if: request channel (mode, key, value) with valid/ready
// depends on hbm_pkg
interface hbm_req_if
	import hbm_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [DATA_W-1:0] key;
	logic [DATA_W-1:0] value;

	modport source (output valid, mode, key, value, input ready);
	modport sink (input valid, mode, key, value, output ready);
endinterface

### hw/rtl/hbm_rsp_if.sv
// hbm_rsp_if: response channel (read_value, hit, bucket_full) with valid/ready
// depends on hbm_pkg
interface hbm_rsp_if
	import hbm_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_value;
	logic              hit;
	logic              bucket_full;

	modport source (output valid, read_value, hit, bucket_full, input ready);
	modport sink (input valid, read_value, hit, bucket_full, output ready);
endinterface

### hw/rtl/hbm_front.sv
// hbm_front: accepts requests, decodes the operation and bucket, two-entry queue
// depends on hbm_pkg, hbm_req_if
module hbm_front
	import hbm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	hbm_req_if.sink    req,
	output logic       head_valid,
	output cmd_t       head,
	input  logic       pop
);
	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cmd_in;

	always_comb begin
		case (req.mode)
			MODE_GET:   cmd_in.op = OP_GET;
			MODE_SET:   cmd_in.op = OP_SET;
			MODE_CLEAR: cmd_in.op = OP_CLR;
			default:    cmd_in.op = OP_NOP;
		endcase
		cmd_in.bucket = req.key[BKT_W-1:0];
		cmd_in.key    = req.key;
		cmd_in.value  = req.value;
	end

	assign req.ready  = (cnt_q != 2'd2);
	assign push       = req.valid && req.ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### hw/rtl/hbm_back.sv
// hbm_back: executes queued requests against the fill store and the slot stores
// depends on hbm_pkg, hbm_rsp_if
module hbm_back
	import hbm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head,
	output logic       pop,
	hbm_rsp_if.source  rsp
);
	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic [FILL_W-1:0] fill_q;
	logic [ROW_W-1:0]  row_q;
	logic [BKT_W-1:0]  clr_q;
	logic [DATA_W-1:0] res_val_q;
	logic              res_hit_q;
	logic              res_full_q;
	logic              out_v_q;
	logic [DATA_W-1:0] out_val_q;
	logic              out_hit_q;
	logic              out_full_q;

	logic [FILL_W-1:0] fill_mem [BUCKETS];
	logic [FILL_W-1:0] fill_rd;
	logic              fill_we;
	logic [FILL_W-1:0] fill_wdata;
	logic [BKT_W-1:0]  fill_waddr;

	logic [DATA_W-1:0] key_rd [LANES];
	logic [DATA_W-1:0] val_rd [LANES];
	logic [LANES-1:0]  key_we;
	logic [LANES-1:0]  val_we;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [ROW_W-1:0]  rrow;

	logic [FILL_W-1:0] cur_fill;
	logic [LANES-1:0]  lane_hit;
	logic              hit_any;
	logic [LANE_W-1:0] hit_lane;
	logic              last_row;
	logic              miss_done;
	logic              can_add;
	logic              out_free;

	// fill store
	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		fill_rd <= fill_mem[head.bucket];
	end

	// slot stores, one bank per lane
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [DATA_W-1:0] key_mem [BUCKETS*ROWS];
		logic [DATA_W-1:0] val_mem [BUCKETS*ROWS];
		always_ff @(posedge clk) begin
			if (key_we[l]) begin
				key_mem[waddr] <= cmd_q.key;
			end
			if (val_we[l]) begin
				val_mem[waddr] <= cmd_q.value;
			end
			key_rd[l] <= key_mem[raddr];
			val_rd[l] <= val_mem[raddr];
		end
	end

	assign rrow     = (state_q == ST_SCAN) ? row_q + 1'b1 : '0;
	assign raddr    = {cmd_q.bucket, rrow};
	assign cur_fill = (state_q == ST_FILL) ? fill_rd : fill_q;
	assign can_add  = (cur_fill < FILL_W'(SLOTS));
	assign out_free = !out_v_q || rsp.ready;
	assign last_row = ((FILL_W'({1'b0, row_q}) + 1'b1) << LANE_W) >= fill_q;

	always_comb begin
		hit_any  = 1'b0;
		hit_lane = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			lane_hit[l] = (FILL_W'({row_q, LANE_W'(l)}) < fill_q)
				&& (key_rd[l] == cmd_q.key);
			if (lane_hit[l]) begin
				hit_any  = 1'b1;
				hit_lane = LANE_W'(l);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		fill_we    = 1'b0;
		fill_waddr = cmd_q.bucket;
		fill_wdata = cur_fill + 1'b1;
		key_we     = '0;
		val_we     = '0;
		waddr      = {cmd_q.bucket, cur_fill[SLOT_W-1:LANE_W]};
		miss_done  = 1'b0;
		case (state_q)
			ST_INIT, ST_CLR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
				fill_wdata = '0;
				if (&clr_q) begin
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
				end
			end
			ST_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					case (head.op)
						OP_GET, OP_SET: state_d = ST_FILL;
						OP_CLR:         state_d = ST_CLR;
						default:        state_d = ST_RESP;
					endcase
				end
			end
			ST_FILL: begin
				if (fill_rd == '0) begin
					miss_done = 1'b1;
					state_d   = ST_RESP;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit_any) begin
					state_d = ST_RESP;
					if (cmd_q.op == OP_SET) begin
						waddr          = {cmd_q.bucket, row_q};
						val_we[hit_lane] = 1'b1;
					end
				end else if (last_row) begin
					miss_done = 1'b1;
					state_d   = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (miss_done && cmd_q.op == OP_SET && can_add) begin
			fill_we = 1'b1;
			key_we[cur_fill[LANE_W-1:0]] = 1'b1;
			val_we[cur_fill[LANE_W-1:0]] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q      <= head;
			res_val_q  <= '0;
			res_hit_q  <= 1'b0;
			res_full_q <= 1'b0;
		end
		if (state_q == ST_FILL) begin
			fill_q <= fill_rd;
			row_q  <= '0;
		end
		if (state_q == ST_SCAN) begin
			row_q <= row_q + 1'b1;
			if (hit_any) begin
				res_hit_q <= 1'b1;
				if (cmd_q.op == OP_GET) begin
					res_val_q <= val_rd[hit_lane];
				end
			end
		end
		if (miss_done && cmd_q.op == OP_SET && !can_add) begin
			res_full_q <= 1'b1;
		end
		if (state_q == ST_RESP && out_free) begin
			out_val_q  <= res_val_q;
			out_hit_q  <= res_hit_q;
			out_full_q <= res_full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_RESP && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.read_value  = out_val_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.bucket_full = out_full_q;
endmodule

### hw/rtl/bucketed_hash_map_engine_unit.sv
// bucketed_hash_map_engine_unit: top level of the bucketed hash map engine
// depends on hbm_pkg, hbm_req_if, hbm_rsp_if, hbm_front, hbm_back
//
// req channel carries one request: mode (get, set, clear), key and value.
// rsp channel returns one response per request, in order: read_value,
// hit and bucket_full.
// a front queue of two requests takes new work while the back end runs.
// get and set go from the queue through a fill count read, a row by row
// scan of the slot stores (one row of four slots a cycle, 0 to 8 rows) and
// the response state into the output register; an unused mode goes
// straight to the response state. the back end takes the next request
// only once it has handed the last one on; a clear walks every bucket
// fill count, and the engine clears every one of them after reset before
// the first request leaves the queue; the queue still takes up to two
// requests.
// when the receiver stalls, the response holds in the output register, one
// more finishes and waits, then the queue fills and req.ready drops.
module bucketed_hash_map_engine_unit
	import hbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hbm_req_if.sink   req,
	hbm_rsp_if.source rsp
);
	logic head_valid;
	cmd_t head;
	logic pop;

	hbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	hbm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);
endmodule
